// ===== rtl/core/lhre_pkg.sv =====
// Shared types, codes and sizes for the lattice hop release engine.
package lhre_pkg;

  // Lattice geometry
  localparam int MAX_SIDE = 32;
  localparam int MIN_SIDE = 3;
  localparam int COORD_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int ADDR_W   = 3 * COORD_W;
  localparam int DEPTH    = MAX_SIDE * MAX_SIDE * MAX_SIDE;

  // Counters
  localparam int COUNT_W = 15;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_SIDE   = 1'b0,
    REG_TARGET = 1'b1
  } reg_index_t;

  // Action codes
  typedef enum logic [1:0] {
    ACT_FORM = 2'd0,
    ACT_PORE = 2'd1,
    ACT_HOP  = 2'd2,
    ACT_HOP2 = 2'd3
  } action_t;

  // Direction codes
  typedef enum logic [2:0] {
    DIR_XP = 3'd0,
    DIR_XM = 3'd1,
    DIR_YP = 3'd2,
    DIR_YM = 3'd3,
    DIR_ZM = 3'd4,
    DIR_ZP = 3'd5
  } direction_t;

  // Cell contents
  typedef enum logic [1:0] {
    CELL_EMPTY = 2'd0,
    CELL_PART  = 2'd1,
    CELL_WALL  = 2'd2,
    CELL_EXIT  = 2'd3
  } cell_t;

  // Outcome codes
  typedef enum logic [2:0] {
    OUT_FORMED   = 3'd0,
    OUT_PLACED   = 3'd1,
    OUT_REJECTED = 3'd2,
    OUT_NO_PART  = 3'd3,
    OUT_MOVED    = 3'd4,
    OUT_EXITED   = 3'd5,
    OUT_BLOCKED  = 3'd6
  } outcome_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FORM,
    ST_PORE,
    ST_RD_SRC,
    ST_RD_NBR,
    ST_DECIDE,
    ST_WR_SRC,
    ST_DONE
  } state_t;

  // Request and result payloads
  typedef struct packed {
    logic [1:0]         action;
    logic [COORD_W-1:0] site_x;
    logic [COORD_W-1:0] site_y;
    logic [COORD_W-1:0] site_z;
    logic [2:0]         direction;
  } req_t;

  typedef struct packed {
    logic [2:0]         outcome;
    logic [COUNT_W-1:0] remaining_count;
    logic [COUNT_W-1:0] released_count;
    logic               target_reached;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic form_step;
    logic pore_step;
    logic rd_src;
    logic rd_nbr;
    logic decide;
    logic wr_src;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sweep_last;
    logic src_part;
    logic nbr_ok;
    logic nbr_empty;
  } dp_stat_t;

endpackage

// ===== rtl/core/lhre_ram.sv =====
// Generic single-port RAM with registered read data.
module lhre_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle; a read returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/lhre_ctrl.sv =====
// Controller state machine that sequences form, pore and hop requests.
module lhre_ctrl
  import lhre_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] action,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          case (action)
            ACT_FORM: state_next = ST_FORM;
            ACT_PORE: state_next = ST_PORE;
            default:  state_next = ST_RD_SRC;
          endcase
        end
      end
      ST_FORM: begin
        cmd.form_step = 1'b1;
        if (stat.sweep_last) begin
          state_next = ST_DONE;
        end
      end
      ST_PORE: begin
        cmd.pore_step = 1'b1;
        state_next    = ST_DONE;
      end
      ST_RD_SRC: begin
        cmd.rd_src = 1'b1;
        state_next = ST_RD_NBR;
      end
      ST_RD_NBR: begin
        // No particle or a neighbor off the lattice ends the hop here.
        cmd.rd_nbr = 1'b1;
        if (stat.src_part && stat.nbr_ok) begin
          state_next = ST_DECIDE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.nbr_empty) begin
          state_next = ST_WR_SRC;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_WR_SRC: begin
        cmd.wr_src = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/lhre_dpath.sv =====
// Datapath: cell store, address and cell logic, particle counters.
module lhre_dpath
  import lhre_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  req_t               request,
  input  logic [SIDE_W-1:0]  lattice_side,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic [2:0]         outcome,
  output logic [COUNT_W-1:0] remaining,
  output logic [COUNT_W-1:0] released
);

  req_t               req_q;
  logic [SIDE_W-1:0]  side_use;
  logic [SIDE_W-1:0]  side_last;
  logic [ADDR_W-1:0]  sweep_cnt;
  logic [COUNT_W-1:0] tally;
  logic [COUNT_W-1:0] tally_next;
  logic [COORD_W-1:0] sx, sy, sz;
  logic               sweep_in, sweep_shell;
  logic [1:0]         sweep_val;
  logic               src_in, pore_ok;
  logic               rim_x, rim_y, rim_z;
  logic [SIDE_W-1:0]  nx, ny, nz;
  logic               nbr_valid, nbr_in;
  logic [ADDR_W-1:0]  src_addr, nbr_addr;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [1:0]         mem_wdata;
  logic [1:0]         mem_rdata;

  // Side clamped to the supported range
  always_comb begin
    side_use = lattice_side;
    if (lattice_side < SIDE_W'(MIN_SIDE)) begin
      side_use = SIDE_W'(MIN_SIDE);
    end else if (lattice_side > SIDE_W'(MAX_SIDE)) begin
      side_use = SIDE_W'(MAX_SIDE);
    end
  end
  assign side_last = side_use - SIDE_W'(1);

  // Form sweep cell: wall on the shell, particle inside, empty beyond the side.
  assign sx = sweep_cnt[ADDR_W-1 -: COORD_W];
  assign sy = sweep_cnt[2*COORD_W-1 -: COORD_W];
  assign sz = sweep_cnt[COORD_W-1:0];
  assign sweep_in = ({1'b0, sx} < side_use) && ({1'b0, sy} < side_use) &&
                    ({1'b0, sz} < side_use);
  assign sweep_shell = (sx == '0) || ({1'b0, sx} == side_last) ||
                       (sy == '0) || ({1'b0, sy} == side_last) ||
                       (sz == '0) || ({1'b0, sz} == side_last);
  assign sweep_val = !sweep_in ? CELL_EMPTY : (sweep_shell ? CELL_WALL : CELL_PART);
  assign tally_next = (sweep_val == CELL_PART && tally != COUNT_MAX) ?
                      tally + COUNT_W'(1) : tally;

  // Addressed site and pore eligibility (exactly one coordinate on the rim)
  assign src_in = ({1'b0, req_q.site_x} < side_use) &&
                  ({1'b0, req_q.site_y} < side_use) &&
                  ({1'b0, req_q.site_z} < side_use);
  assign rim_x = (req_q.site_x == '0) || ({1'b0, req_q.site_x} == side_last);
  assign rim_y = (req_q.site_y == '0) || ({1'b0, req_q.site_y} == side_last);
  assign rim_z = (req_q.site_z == '0) || ({1'b0, req_q.site_z} == side_last);
  assign pore_ok = src_in && (rim_x ^ rim_y ^ rim_z) && !(rim_x && rim_y && rim_z);
  assign src_addr = {req_q.site_x, req_q.site_y, req_q.site_z};

  // Neighbor coordinates; an underflow or unknown direction acts as a wall.
  always_comb begin
    nx        = {1'b0, req_q.site_x};
    ny        = {1'b0, req_q.site_y};
    nz        = {1'b0, req_q.site_z};
    nbr_valid = 1'b1;
    case (req_q.direction)
      DIR_XP: nx = nx + SIDE_W'(1);
      DIR_XM: begin
        if (req_q.site_x == '0) nbr_valid = 1'b0;
        else nx = nx - SIDE_W'(1);
      end
      DIR_YP: ny = ny + SIDE_W'(1);
      DIR_YM: begin
        if (req_q.site_y == '0) nbr_valid = 1'b0;
        else ny = ny - SIDE_W'(1);
      end
      DIR_ZM: begin
        if (req_q.site_z == '0) nbr_valid = 1'b0;
        else nz = nz - SIDE_W'(1);
      end
      DIR_ZP: nz = nz + SIDE_W'(1);
      default: nbr_valid = 1'b0;
    endcase
  end
  assign nbr_in = nbr_valid && (nx < side_use) && (ny < side_use) && (nz < side_use);
  assign nbr_addr = {nx[COORD_W-1:0], ny[COORD_W-1:0], nz[COORD_W-1:0]};

  // Status back to the controller
  assign stat.sweep_last = &sweep_cnt;
  assign stat.src_part   = src_in && (mem_rdata == CELL_PART);
  assign stat.nbr_ok     = nbr_in;
  assign stat.nbr_empty  = (mem_rdata == CELL_EMPTY);

  // Single memory port: one read or one write per cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = src_addr;
    mem_wdata = CELL_EMPTY;
    if (cmd.form_step) begin
      mem_we    = 1'b1;
      mem_addr  = sweep_cnt;
      mem_wdata = sweep_val;
    end else if (cmd.pore_step) begin
      mem_we    = pore_ok;
      mem_wdata = CELL_EXIT;
    end else if (cmd.rd_src) begin
      mem_addr = src_addr;
    end else if (cmd.rd_nbr) begin
      mem_addr = nbr_addr;
    end else if (cmd.decide) begin
      if (mem_rdata == CELL_EXIT) begin
        mem_we = 1'b1;
      end else if (mem_rdata == CELL_EMPTY) begin
        mem_we    = 1'b1;
        mem_addr  = nbr_addr;
        mem_wdata = CELL_PART;
      end
    end else if (cmd.wr_src) begin
      mem_we = 1'b1;
    end
  end

  lhre_ram #(
    .WIDTH(2),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // Request capture, sweep counter and outcome
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q     <= request;
      sweep_cnt <= '0;
      tally     <= '0;
    end
    if (cmd.form_step) begin
      sweep_cnt <= sweep_cnt + ADDR_W'(1);
      tally     <= tally_next;
      outcome   <= OUT_FORMED;
    end
    if (cmd.pore_step) begin
      outcome <= pore_ok ? OUT_PLACED : OUT_REJECTED;
    end
    if (cmd.rd_nbr) begin
      if (!stat.src_part) outcome <= OUT_NO_PART;
      else if (!nbr_in) outcome <= OUT_BLOCKED;
    end
    if (cmd.decide) begin
      if (mem_rdata == CELL_EXIT) outcome <= OUT_EXITED;
      else if (mem_rdata == CELL_EMPTY) outcome <= OUT_MOVED;
      else outcome <= OUT_BLOCKED;
    end
  end

  // Particle counters
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      released  <= '0;
    end else if (cmd.form_step && stat.sweep_last) begin
      remaining <= tally_next;
      released  <= '0;
    end else if (cmd.decide && mem_rdata == CELL_EXIT) begin
      if (remaining != '0) remaining <= remaining - COUNT_W'(1);
      if (released != COUNT_MAX) released <= released + COUNT_W'(1);
    end
  end

endmodule

// ===== rtl/core/lattice_hop_release_engine.sv =====
// Top level of the lattice hop release engine: configuration, controller, datapath.
//
// A request is taken when start is high and busy is low; its result appears
// on result for exactly one cycle with done high and cannot be held off.
// All cell reads and writes share one port of a 32768-entry cell store with
// registered read data, and that port sets the order of steps: a hop holds
// busy through a source read, a neighbor read, a decision when the particle
// has a neighbor on the lattice (with a write when that neighbor is a pore or
// empty), a second write when the particle moves, and the result; a pore
// placement through a placement step and the result; a form request writes
// every cell of the full store once, one per cycle, before its result. Cell
// contents are undefined until the first form request. Configuration writes
// are always ready and must only be issued while the block is idle.
module lattice_hop_release_engine
  import lhre_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  req_t               request,
  output logic               done,
  output res_t               result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [COUNT_W-1:0] cfg_data
);

  logic [SIDE_W-1:0]  lattice_side;
  logic [COUNT_W-1:0] release_target;
  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [2:0]         outcome;
  logic [COUNT_W-1:0] remaining;
  logic [COUNT_W-1:0] released;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_side   <= SIDE_W'(32);
      release_target <= COUNT_W'(26997);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIDE:   lattice_side   <= cfg_data[SIDE_W-1:0];
        REG_TARGET: release_target <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Controller
  lhre_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .action(request.action),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath
  lhre_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .lattice_side(lattice_side),
    .cmd         (cmd),
    .stat        (stat),
    .outcome     (outcome),
    .remaining   (remaining),
    .released    (released)
  );

  // Result payload
  assign result.outcome         = outcome;
  assign result.remaining_count = remaining;
  assign result.released_count  = released;
  assign result.target_reached  = (released == release_target);

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  // The result strobe lasts a single cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // A move leaves the particle count untouched.
  a_move_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.outcome == OUT_MOVED) |-> $stable(result.remaining_count))
    else $error("remaining count changed on a move");

  // Forming the lattice clears the released count.
  a_form_clears: assert property (@(posedge clk) disable iff (rst)
    (done && result.outcome == OUT_FORMED) |-> (result.released_count == '0))
    else $error("released count not cleared by form");

endmodule

// ===== tb/sv/tb_lattice_hop_release_engine.sv =====
// Self-checking testbench for the lattice hop release engine with a built-in lattice predictor.
`timescale 1ns / 100ps

module tb_lattice_hop_release_engine;
  import lhre_pkg::*;

  // Cycles without any handshake before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int MAX_REPORTS    = 10;

  // Direction codes that carry no meaning in a hop request.
  localparam logic [2:0] DIR_NONE_A = 3'd6;
  localparam logic [2:0] DIR_NONE_B = 3'd7;

  // A pore on a face, with the hop direction that leads into it from inside.
  typedef struct {
    int         x;
    int         y;
    int         z;
    direction_t toward;
  } pore_site_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  req_t               request = '0;
  logic               done;
  res_t               result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [0:0]         cfg_index = REG_SIDE;
  logic [COUNT_W-1:0] cfg_data = '0;

  // Stimulus bookkeeping.
  req_t       lattice_requests [$];
  pore_site_t open_pores [$];
  int         gen_side = MAX_SIDE;
  bit         sender_idles = 1'b1;
  int         gap_left = 0;
  logic       req_taken = 1'b0;

  // Predicted lattice state and register copies.
  cell_t              lattice_cells [DEPTH];
  logic [COUNT_W-1:0] remain_cnt = '0;
  logic [COUNT_W-1:0] release_cnt = '0;
  logic [SIDE_W-1:0]  side_reg = SIDE_W'(MAX_SIDE);
  logic [COUNT_W-1:0] target_reg = COUNT_W'(26997);
  res_t               predicted_reports [$];

  int error_count = 0;
  int result_index = 0;
  int stall_cycles = 0;

  lattice_hop_release_engine uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Lattice predictor
  // ---------------------------------------------------------------------

  function automatic int bounded_side(int raw);
    if (raw < MIN_SIDE) return MIN_SIDE;
    if (raw > MAX_SIDE) return MAX_SIDE;
    return raw;
  endfunction

  function automatic int cell_addr(int x, int y, int z);
    return (x * MAX_SIDE + y) * MAX_SIDE + z;
  endfunction

  function automatic bit on_rim(int c, int s);
    return (c == 0) || (c == s - 1);
  endfunction

  // Cells beyond the current side behave as wall.
  function automatic cell_t cell_at(int x, int y, int z, int s);
    if (x >= s || y >= s || z >= s) return CELL_WALL;
    return lattice_cells[cell_addr(x, y, z)];
  endfunction

  function automatic res_t predict_lattice_action(req_t rq);
    res_t  rs;
    int    s, x, y, z, nx, ny, nz, inner, rims, i, j, k;
    bit    nbr_ok;
    cell_t nbr;
    s = bounded_side(side_reg);
    x = rq.site_x;
    y = rq.site_y;
    z = rq.site_z;
    rs = '0;
    case (action_t'(rq.action))
      ACT_FORM: begin
        // The whole store is cleared, then walls on the shell and particles inside.
        for (i = 0; i < DEPTH; i++) lattice_cells[i] = CELL_EMPTY;
        for (i = 0; i < s; i++)
          for (j = 0; j < s; j++)
            for (k = 0; k < s; k++)
              lattice_cells[cell_addr(i, j, k)] =
                (on_rim(i, s) || on_rim(j, s) || on_rim(k, s)) ? CELL_WALL : CELL_PART;
        inner = s - 2;
        if (inner * inner * inner > COUNT_MAX) remain_cnt = COUNT_MAX;
        else remain_cnt = COUNT_W'(inner * inner * inner);
        release_cnt = '0;
        rs.outcome = OUT_FORMED;
      end
      ACT_PORE: begin
        // Only a face cell that touches exactly one rim takes a pore.
        rs.outcome = OUT_REJECTED;
        if (x < s && y < s && z < s) begin
          rims = int'(on_rim(x, s)) + int'(on_rim(y, s)) + int'(on_rim(z, s));
          if (rims == 1) begin
            lattice_cells[cell_addr(x, y, z)] = CELL_EXIT;
            rs.outcome = OUT_PLACED;
          end
        end
      end
      default: begin
        if (x >= s || y >= s || z >= s || cell_at(x, y, z, s) != CELL_PART) begin
          rs.outcome = OUT_NO_PART;
        end else begin
          nx = x;
          ny = y;
          nz = z;
          nbr_ok = 1'b1;
          case (direction_t'(rq.direction))
            DIR_XP: nx = x + 1;
            DIR_XM: if (x == 0) nbr_ok = 1'b0; else nx = x - 1;
            DIR_YP: ny = y + 1;
            DIR_YM: if (y == 0) nbr_ok = 1'b0; else ny = y - 1;
            DIR_ZM: if (z == 0) nbr_ok = 1'b0; else nz = z - 1;
            DIR_ZP: nz = z + 1;
            default: nbr_ok = 1'b0;
          endcase
          nbr = nbr_ok ? cell_at(nx, ny, nz, s) : CELL_WALL;
          if (nbr == CELL_EXIT) begin
            lattice_cells[cell_addr(x, y, z)] = CELL_EMPTY;
            if (remain_cnt != '0) remain_cnt = remain_cnt - 1'b1;
            if (release_cnt != COUNT_MAX) release_cnt = release_cnt + 1'b1;
            rs.outcome = OUT_EXITED;
          end else if (nbr == CELL_EMPTY) begin
            lattice_cells[cell_addr(nx, ny, nz)] = CELL_PART;
            lattice_cells[cell_addr(x, y, z)] = CELL_EMPTY;
            rs.outcome = OUT_MOVED;
          end else begin
            rs.outcome = OUT_BLOCKED;
          end
        end
      end
    endcase
    rs.remaining_count = remain_cnt;
    rs.released_count = release_cnt;
    rs.target_reached = (release_cnt == target_reg);
    return rs;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic req_t make_req(action_t act, int x, int y, int z, int dir);
    req_t r;
    r.action = act;
    r.site_x = COORD_W'(x);
    r.site_y = COORD_W'(y);
    r.site_z = COORD_W'(z);
    r.direction = 3'(dir);
    return r;
  endfunction

  // Place a pore on a random face cell away from the edges and remember it.
  task automatic push_face_pore();
    pore_site_t p;
    p.x = $urandom_range(1, gen_side - 2);
    p.y = $urandom_range(1, gen_side - 2);
    p.z = $urandom_range(1, gen_side - 2);
    p.toward = direction_t'($urandom_range(DIR_XP, DIR_ZP));
    case (p.toward)
      DIR_XM:  p.x = 0;
      DIR_XP:  p.x = gen_side - 1;
      DIR_YM:  p.y = 0;
      DIR_YP:  p.y = gen_side - 1;
      DIR_ZM:  p.z = 0;
      default: p.z = gen_side - 1;
    endcase
    open_pores.push_back(p);
    lattice_requests.push_back(make_req(ACT_PORE, p.x, p.y, p.z, $urandom_range(0, 7)));
  endtask

  // Mostly hops that march particles toward known pores, then interior hops,
  // noise requests and further pores.
  task automatic push_random_items(int count);
    pore_site_t p;
    int pick, depth, x, y, z;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 && open_pores.size() != 0) begin
        p = open_pores[$urandom_range(0, open_pores.size() - 1)];
        depth = $urandom_range(1, (gen_side - 2 < 3) ? gen_side - 2 : 3);
        x = p.x;
        y = p.y;
        z = p.z;
        case (p.toward)
          DIR_XM:  x = depth;
          DIR_XP:  x = gen_side - 1 - depth;
          DIR_YM:  y = depth;
          DIR_YP:  y = gen_side - 1 - depth;
          DIR_ZM:  z = depth;
          default: z = gen_side - 1 - depth;
        endcase
        lattice_requests.push_back(make_req(($urandom_range(0, 7) == 0) ? ACT_HOP2 : ACT_HOP,
                                            x, y, z, p.toward));
      end else if (pick < 75) begin
        lattice_requests.push_back(make_req(ACT_HOP,
                                            $urandom_range(1, gen_side - 2),
                                            $urandom_range(1, gen_side - 2),
                                            $urandom_range(1, gen_side - 2),
                                            $urandom_range(DIR_XP, DIR_ZP)));
      end else if (pick < 87) begin
        lattice_requests.push_back(make_req($urandom_range(0, 1) ? ACT_HOP2 : ACT_HOP,
                                            $urandom_range(0, MAX_SIDE - 1),
                                            $urandom_range(0, MAX_SIDE - 1),
                                            $urandom_range(0, MAX_SIDE - 1),
                                            $urandom_range(0, 7)));
      end else if (pick < 95) begin
        push_face_pore();
      end else begin
        lattice_requests.push_back(make_req(ACT_PORE,
                                            $urandom_range(0, MAX_SIDE - 1),
                                            $urandom_range(0, MAX_SIDE - 1),
                                            $urandom_range(0, MAX_SIDE - 1),
                                            $urandom_range(0, 7)));
      end
    end
  endtask

  // Wait until every request is taken and every result is back.
  task automatic wait_for_drain();
    while (lattice_requests.size() != 0 || start || predicted_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(reg_index_t idx, logic [COUNT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SIDE) side_reg = value[SIDE_W-1:0];
    else target_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reconfigure an idle block and queue the opening requests of a phase.
  task automatic start_phase(int side_val, int target_val, bit do_form, int pore_count,
                             bit idle_on);
    wait_for_drain();
    write_register(REG_SIDE, {9'($urandom_range(0, 511)), SIDE_W'(side_val)});
    write_register(REG_TARGET, COUNT_W'(target_val));
    gen_side = bounded_side(side_val);
    sender_idles = idle_on;
    open_pores.delete();
    if (do_form)
      lattice_requests.push_back(make_req(ACT_FORM, $urandom_range(0, MAX_SIDE - 1),
                                          $urandom_range(0, MAX_SIDE - 1),
                                          $urandom_range(0, MAX_SIDE - 1),
                                          $urandom_range(0, 7)));
    repeat (pore_count) push_face_pore();
  endtask

  // ---------------------------------------------------------------------
  // Request driver: changes inputs on the falling edge.
  // ---------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (lattice_requests.size() == 0) begin
        start <= 1'b0;
      end else if (sender_idles && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        gap_left <= $urandom_range(0, 3);
      end else begin
        request <= lattice_requests.pop_front();
        start <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks results and predicts accepted requests on the rising edge.
  // ---------------------------------------------------------------------

  task automatic note_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic check_result(res_t got);
    res_t want;
    if (predicted_reports.size() == 0) begin
      note_error($sformatf("Result %0d arrived with no request outstanding (outcome %0d)",
                           result_index, got.outcome));
    end else begin
      want = predicted_reports.pop_front();
      if (got.outcome !== want.outcome)
        note_error($sformatf("Result %0d outcome: expected %0d, got %0d",
                             result_index, want.outcome, got.outcome));
      if (got.remaining_count !== want.remaining_count)
        note_error($sformatf("Result %0d remaining_count: expected %0d, got %0d",
                             result_index, want.remaining_count, got.remaining_count));
      if (got.released_count !== want.released_count)
        note_error($sformatf("Result %0d released_count: expected %0d, got %0d",
                             result_index, want.released_count, got.released_count));
      if (got.target_reached !== want.target_reached)
        note_error($sformatf("Result %0d target_reached: expected %0d, got %0d",
                             result_index, want.target_reached, got.target_reached));
    end
    result_index++;
  endtask

  always @(posedge clk) begin
    req_taken <= !rst && start && !busy;
    if (!rst) begin
      if (done) check_result(result);
      if (start && !busy) predicted_reports.push_back(predict_lattice_action(request));
    end
  end

  // Watchdog: any handshake restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", predicted_reports.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------

  initial begin
    for (int i = 0; i < DEPTH; i++) lattice_cells[i] = CELL_EMPTY;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed checks on a side-5 lattice with a target of one release.
    start_phase(5, 1, 1'b1, 0, 1'b1);
    lattice_requests.push_back(make_req(ACT_PORE, 0, 2, 2, DIR_XP));
    // Edge, corner, interior and out-of-lattice pores are all rejected.
    lattice_requests.push_back(make_req(ACT_PORE, 0, 0, 2, DIR_XP));
    lattice_requests.push_back(make_req(ACT_PORE, 0, 0, 0, DIR_XP));
    lattice_requests.push_back(make_req(ACT_PORE, 2, 2, 2, DIR_XP));
    lattice_requests.push_back(make_req(ACT_PORE, MAX_SIDE - 1, MAX_SIDE - 1,
                                        MAX_SIDE - 1, DIR_NONE_B));
    // A second pore on the same cell is placed again.
    lattice_requests.push_back(make_req(ACT_PORE, 4, 2, 2, DIR_XP));
    lattice_requests.push_back(make_req(ACT_PORE, 4, 2, 2, DIR_XP));
    lattice_requests.push_back(make_req(ACT_PORE, 2, 2, 0, DIR_XP));
    lattice_requests.push_back(make_req(ACT_PORE, 2, 2, 4, DIR_XP));
    lattice_requests.push_back(make_req(ACT_PORE, 2, 0, 2, DIR_XP));
    lattice_requests.push_back(make_req(ACT_PORE, 2, 4, 2, DIR_XP));
    // Hops on a wall and outside the lattice find no particle.
    lattice_requests.push_back(make_req(ACT_HOP, 0, 1, 1, DIR_XP));
    lattice_requests.push_back(make_req(ACT_HOP, MAX_SIDE - 1, 2, 2, DIR_XM));
    // Exit through a pore reaches the target, then a wall block and a move.
    lattice_requests.push_back(make_req(ACT_HOP, 1, 2, 2, DIR_XM));
    lattice_requests.push_back(make_req(ACT_HOP, 1, 1, 1, DIR_XM));
    lattice_requests.push_back(make_req(ACT_HOP, 2, 2, 2, DIR_XM));
    lattice_requests.push_back(make_req(ACT_HOP, 2, 2, 2, DIR_XM));
    // Directions without meaning block the particle.
    lattice_requests.push_back(make_req(ACT_HOP, 1, 2, 2, DIR_NONE_A));
    lattice_requests.push_back(make_req(ACT_HOP, 1, 2, 2, DIR_NONE_B));
    // The spare action code hops as well.
    lattice_requests.push_back(make_req(ACT_HOP2, 3, 2, 2, DIR_XP));
    lattice_requests.push_back(make_req(ACT_HOP, 1, 1, 1, DIR_ZP));
    lattice_requests.push_back(make_req(ACT_HOP, 2, 2, 3, DIR_ZP));
    lattice_requests.push_back(make_req(ACT_HOP, 2, 3, 2, DIR_YP));
    lattice_requests.push_back(make_req(ACT_HOP, 2, 1, 2, DIR_YM));
    lattice_requests.push_back(make_req(ACT_HOP, 2, 2, 1, DIR_ZM));
    lattice_requests.push_back(make_req(ACT_HOP, 1, 1, 1, DIR_YM));
    push_random_items(100);

    // Side below range saturates to three; a zero target is met right after forming.
    start_phase(0, 0, 1'b1, 2, 1'b1);
    push_random_items(40);

    start_phase(8, 5, 1'b1, 3, 1'b1);
    push_random_items(120);

    // Side above range saturates to the full store; the target equals the full particle count.
    start_phase(63, 27000, 1'b1, 3, 1'b1);
    push_random_items(100);

    // Shrinking the side without forming leaves particles on the new rim.
    start_phase(6, 32767, 1'b0, 3, 1'b1);
    push_random_items(100);

    start_phase(4, 2, 1'b1, 3, 1'b1);
    push_random_items(100);

    // Growing the side without forming exposes cleared cells outside the old shell.
    start_phase(12, 3, 1'b0, 3, 1'b1);
    push_random_items(80);

    start_phase(7, 4, 1'b1, 3, 1'b1);
    push_random_items(120);

    start_phase(2, 1, 1'b0, 2, 1'b1);
    push_random_items(50);

    // Closing phases run back to back with no sender gaps.
    start_phase(10, 8, 1'b1, 3, 1'b0);
    push_random_items(120);

    start_phase(6, 3, 1'b1, 3, 1'b0);
    push_random_items(120);

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
